@@ hdl/sine_wave_led_color_blend_macros.svh @@
// ----------------------------------------------------------------------------
// Sine wave LED color blend: assertion macros
// Concurrent assertion shorthands on clk, quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SINE_WAVE_LED_COLOR_BLEND_MACROS_SVH
`define SINE_WAVE_LED_COLOR_BLEND_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SWLCB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define SWLCB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/swlcb_pkg.sv @@
// ----------------------------------------------------------------------------
// swlcb_pkg
// Widths, register map and sine table generator for the LED color blend.
// ----------------------------------------------------------------------------
package swlcb_pkg;

  localparam int MAX_LEDS         = 1024;
  localparam int SINE_ENTRIES_DEF = 256;

  localparam int PIX_W       = 10;
  localparam int PHASE_W     = 16;
  localparam int TIME_W      = 32;
  localparam int CH_W        = 8;
  localparam int COLOR_W     = 24;
  localparam int LEVEL_W     = 9;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  // serial multipliers retire two multiplier bits per cycle
  localparam int MUL_STEPS   = PHASE_W / 2;
  localparam int BLEND_STEPS = (LEVEL_W + 1) / 2;
  localparam int CNT_W       = 3;

  localparam logic [LEVEL_W-1:0] LEVEL_MID = 9'd128;
  localparam logic [7:0]         SINE_PEAK = 8'd128;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_HALF    = 64'd536870912;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE     = 3'd0,
    CFG_PHASE_STEP = 3'd1,
    CFG_SPEED      = 3'd2,
    CFG_OFFSET     = 3'd3,
    CFG_TIME_STEP  = 3'd4,
    CFG_COLOR_HIGH = 3'd5,
    CFG_COLOR_LOW  = 3'd6
  } cfg_reg_t;

  // round(128 * sin(x)), x in Q30 radians over a quarter turn; evaluated at
  // elaboration only
  function automatic logic [7:0] sine_q7(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x2 = (x * x) >> 30;
    t  = x;
    s  = x;
    t  = ((t * x2) >> 30) / 64'd6;
    s  = s - t;
    t  = ((t * x2) >> 30) / 64'd20;
    s  = s + t;
    t  = ((t * x2) >> 30) / 64'd42;
    s  = s - t;
    t  = ((t * x2) >> 30) / 64'd72;
    s  = s + t;
    t  = ((t * x2) >> 30) / 64'd110;
    s  = s - t;
    t  = ((t * x2) >> 30) / 64'd156;
    s  = s + t;
    t  = ((t * x2) >> 30) / 64'd210;
    s  = s - t;
    s  = (s * 64'd128 + Q30_HALF) >> 30;
    if (s > 64'd128) begin
      s = 64'd128;
    end
    return s[7:0];
  endfunction

endpackage

@@ hdl/sine_wave_led_color_blend.sv @@
// ----------------------------------------------------------------------------
// sine_wave_led_color_blend: per pixel sine wave color blend, two-bit digit serial
// Steps per pixel: 8 multiply steps, phase, lookup, 5 blend steps and the handoff
// to the result register, which waits for a free output slot; a disabled pixel goes
// straight to the handoff. The next pixel is taken at that handoff.
// Reset: synchronous active-low; registers to defaults, frame time zero, no result.
// ----------------------------------------------------------------------------
module sine_wave_led_color_blend
  import swlcb_pkg::*;
#(
  parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [9:0] pixel_index
  input  logic                   in_tlast,   // frame_end
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] red, [15:8] green, [23:16] blue
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int IDX_W  = $clog2(SINE_ENTRIES + 1);
  localparam int PROD_W = 14 + IDX_W;
  localparam int ACC_W  = 20;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_PHASE, S_LOOK, S_BLEND, S_DONE
  } state_t;

  // quarter-wave table
  logic [7:0] sine_rom [SINE_ENTRIES+1];

  for (genvar gi = 0; gi <= SINE_ENTRIES; gi++) begin : g_rom
    localparam logic [63:0] ANGLE = (64'(gi) * HALF_PI_Q30) / SINE_ENTRIES;
    if (gi == 0) begin : g_zero
      assign sine_rom[gi] = 8'd0;
    end else if (gi == SINE_ENTRIES) begin : g_peak
      assign sine_rom[gi] = SINE_PEAK;
    end else begin : g_mid
      assign sine_rom[gi] = sine_q7(ANGLE);
    end
  end

  // configuration registers
  logic                  enable_r;
  logic [PHASE_W-1:0]    k_r;
  logic [PHASE_W-1:0]    speed_r;
  logic [PHASE_W-1:0]    offset_r;
  logic [PHASE_W-1:0]    tstep_r;
  logic [COLOR_W-1:0]    hi_r;
  logic [COLOR_W-1:0]    lo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      k_r      <= '0;
      speed_r  <= '0;
      offset_r <= '0;
      tstep_r  <= '0;
      hi_r     <= '1;
      lo_r     <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ENABLE:     enable_r <= cfg_wdata[0];
        CFG_PHASE_STEP: k_r      <= cfg_wdata[PHASE_W-1:0];
        CFG_SPEED:      speed_r  <= cfg_wdata[PHASE_W-1:0];
        CFG_OFFSET:     offset_r <= cfg_wdata[PHASE_W-1:0];
        CFG_TIME_STEP:  tstep_r  <= cfg_wdata[PHASE_W-1:0];
        CFG_COLOR_HIGH: hi_r     <= cfg_wdata[COLOR_W-1:0];
        CFG_COLOR_LOW:  lo_r     <= cfg_wdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath registers
  state_t                state_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [TIME_W-1:0]     ft_r;
  logic [PHASE_W-1:0]    ws_sh_r;
  logic [TIME_W-1:0]     ft_sh_r;
  logic [TIME_W-1:0]     spd_acc_r;
  logic [PIX_W-1:0]      ix_sh_r;
  logic [PHASE_W-1:0]    k_sh_r;
  logic [PHASE_W-1:0]    k_acc_r;
  logic [PHASE_W-1:0]    phase_r;
  logic [LEVEL_W-1:0]    v_sh_r;
  logic [ACC_W-1:0]      diff_r [3];
  logic [ACC_W-1:0]      bacc_r [3];
  logic                  out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic                  accept;
  logic                  slot_free;
  logic [PIX_W-1:0]      pix_clamped;
  logic [TIME_W-1:0]     spd_acc_nxt;
  logic [PHASE_W-1:0]    k_acc_nxt;
  logic [PHASE_W-1:0]    phase_nxt;
  logic [PROD_W-1:0]     q_prod;
  logic [IDX_W-1:0]      tbl_idx;
  logic [IDX_W-1:0]      tbl_addr;
  logic [7:0]            mag;
  logic [LEVEL_W-1:0]    v_nxt;
  logic [ACC_W-1:0]      bacc_nxt [3];
  logic [ACC_W-1:0]      diff_init [3];
  logic [ACC_W-1:0]      bacc_init [3];
  logic [OUT_TDATA_W-1:0] result;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) || ((state_r == S_DONE) && slot_free);
  assign accept    = in_tvalid && in_tready;

  assign pix_clamped = (32'(in_tdata[PIX_W-1:0]) >= MAX_LEDS) ? PIX_W'(MAX_LEDS - 1)
                                                               : in_tdata[PIX_W-1:0];

  always_comb begin
    // speed * time and k * index, two multiplier bits per step
    spd_acc_nxt = spd_acc_r
                + (ws_sh_r[0] ? ft_sh_r : '0)
                + (ws_sh_r[1] ? {ft_sh_r[TIME_W-2:0], 1'b0} : '0);
    k_acc_nxt   = k_acc_r
                + (ix_sh_r[0] ? k_sh_r : '0)
                + (ix_sh_r[1] ? {k_sh_r[PHASE_W-2:0], 1'b0} : '0);
    // only bits 31:16 of the product survive the Q16.16 truncation and wrap
    phase_nxt   = k_acc_r - spd_acc_r[TIME_W-1:PHASE_W] + offset_r;
  end

  always_comb begin
    q_prod   = PROD_W'(phase_r[13:0]) * PROD_W'(SINE_ENTRIES);
    tbl_idx  = q_prod[PROD_W-1:14];
    // odd quadrants run the table backwards
    tbl_addr = phase_r[14] ? IDX_W'(SINE_ENTRIES) - tbl_idx : tbl_idx;
    mag      = sine_rom[tbl_addr];
    v_nxt    = phase_r[15] ? LEVEL_MID - LEVEL_W'(mag) : LEVEL_MID + LEVEL_W'(mag);
  end

  // blend as lo*256 + v*(hi - lo), v consumed two bits per step
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff_init[c] = ACC_W'(hi_r[COLOR_W-1-CH_W*c -: CH_W])
                   - ACC_W'(lo_r[COLOR_W-1-CH_W*c -: CH_W]);
      bacc_init[c] = ACC_W'({lo_r[COLOR_W-1-CH_W*c -: CH_W], 8'h00});
      bacc_nxt[c]  = bacc_r[c]
                   + (v_sh_r[0] ? diff_r[c] : '0)
                   + (v_sh_r[1] ? {diff_r[c][ACC_W-2:0], 1'b0} : '0);
      result[CH_W*c +: CH_W] = bacc_r[c][15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ft_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_DONE) && slot_free) begin
        out_valid_r <= 1'b1;
        out_data_r  <= result;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (accept) begin
        cnt_r <= '0;
        if (enable_r) begin
          ws_sh_r   <= speed_r;
          ft_sh_r   <= ft_r;
          spd_acc_r <= '0;
          ix_sh_r   <= pix_clamped;
          k_sh_r    <= k_r;
          k_acc_r   <= '0;
          // the shifter keeps the old time for this pixel
          if (in_tlast) begin
            ft_r <= ft_r + TIME_W'(tstep_r);
          end
          state_r <= S_MUL;
        end else begin
          ft_r <= '0;
          for (int c = 0; c < 3; c++) begin
            bacc_r[c] <= '0;
          end
          state_r <= S_DONE;
        end
      end else begin
        unique case (state_r)
          S_IDLE: ;
          S_MUL: begin
            spd_acc_r <= spd_acc_nxt;
            k_acc_r   <= k_acc_nxt;
            ws_sh_r   <= ws_sh_r >> 2;
            ix_sh_r   <= ix_sh_r >> 2;
            ft_sh_r   <= ft_sh_r << 2;
            k_sh_r    <= k_sh_r << 2;
            if (cnt_r == CNT_W'(MUL_STEPS - 1)) begin
              cnt_r   <= '0;
              state_r <= S_PHASE;
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
          S_PHASE: begin
            phase_r <= phase_nxt;
            state_r <= S_LOOK;
          end
          S_LOOK: begin
            v_sh_r <= v_nxt;
            for (int c = 0; c < 3; c++) begin
              diff_r[c] <= diff_init[c];
              bacc_r[c] <= bacc_init[c];
            end
            cnt_r   <= '0;
            state_r <= S_BLEND;
          end
          S_BLEND: begin
            v_sh_r <= v_sh_r >> 2;
            for (int c = 0; c < 3; c++) begin
              diff_r[c] <= diff_r[c] << 2;
              bacc_r[c] <= bacc_nxt[c];
            end
            if (cnt_r == CNT_W'(BLEND_STEPS - 1)) begin
              cnt_r   <= '0;
              state_r <= S_DONE;
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
          S_DONE: begin
            if (slot_free) begin
              state_r <= S_IDLE;
            end
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ hdl/swlcb_checker.sv @@
// ----------------------------------------------------------------------------
// swlcb_checker
// Port-level checks for the LED color blend, bound to the top level.
// ----------------------------------------------------------------------------
`include "sine_wave_led_color_blend_macros.svh"

module swlcb_checker
  import swlcb_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic       in_beat;
  logic       out_beat;
  logic [1:0] pend_r;

  assign in_beat  = in_tvalid && in_tready;
  assign out_beat = out_tvalid && out_tready;

  // pixels taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_beat && !out_beat) begin
      pend_r <= pend_r + 1'b1;
    end else if (out_beat && !in_beat) begin
      pend_r <= pend_r - 1'b1;
    end
  end

  `SWLCB_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result beat changed while stalled")
  `SWLCB_ASSERT_NOW(a_ready_empty, pend_r == 2'd0, in_tready, "input refused with nothing in flight")
  `SWLCB_ASSERT_NOW(a_pend_bound, 1'b1, pend_r != 2'd3, "more than two pixels in flight")
  `SWLCB_ASSERT_NOW(a_no_phantom, out_tvalid, pend_r != 2'd0, "result offered with no pixel pending")

endmodule

bind sine_wave_led_color_blend swlcb_checker u_swlcb_checker (.*);

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// Sine wave LED color blend testbench
// Streams pixel beats through the block under several register settings and
// compares every color beat against a cycle-free model of the phase, sine
// lookup and channel blend. Both stream sides idle at random rates.
// ----------------------------------------------------------------------------
module testbench;
  import swlcb_pkg::*;

  localparam int SINE_N        = SINE_ENTRIES_DEF;
  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_PIXELS  = 142;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic               en;
    logic [PHASE_W-1:0] phase_step;
    logic [PHASE_W-1:0] speed;
    logic [PHASE_W-1:0] offset;
    logic [PHASE_W-1:0] tstep;
    logic [COLOR_W-1:0] color_high;
    logic [COLOR_W-1:0] color_low;
  } wave_cfg_t;

  class color_scoreboard;
    logic                   enable;
    logic [PHASE_W-1:0]     phase_step;
    logic [PHASE_W-1:0]     speed;
    logic [PHASE_W-1:0]     offset;
    logic [PHASE_W-1:0]     time_step;
    logic [COLOR_W-1:0]     color_high;
    logic [COLOR_W-1:0]     color_low;
    logic [TIME_W-1:0]      frame_time;
    logic [7:0]             sine_lut[SINE_N+1];
    logic [OUT_TDATA_W-1:0] expected_colors[$];
    int                     errors;
    int                     pixels_seen;
    int                     frames_seen;

    function new();
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      // quarter-wave table: round(128 * sin) from a Q30 Taylor series
      for (int i = 0; i <= SINE_N; i++) begin
        x  = (64'(i) * HALF_PI_Q30) / 64'(SINE_N);
        x2 = (x * x) >> 30;
        t  = x;
        s  = x;
        for (int n = 1; n <= 7; n++) begin
          t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
          s = (n % 2 == 1) ? s - t : s + t;
        end
        s = (s * 64'd128 + Q30_HALF) >> 30;
        sine_lut[i] = (s > 64'd128) ? SINE_PEAK : s[7:0];
      end
      sine_lut[0]      = 8'd0;
      sine_lut[SINE_N] = SINE_PEAK;
      enable      = 1'b0;
      phase_step  = '0;
      speed       = '0;
      offset      = '0;
      time_step   = '0;
      color_high  = '1;
      color_low   = '0;
      frame_time  = '0;
      errors      = 0;
      pixels_seen = 0;
      frames_seen = 0;
    endfunction

    function void set_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
      case (r)
        CFG_ENABLE:     enable     = v[0];
        CFG_PHASE_STEP: phase_step = v[PHASE_W-1:0];
        CFG_SPEED:      speed      = v[PHASE_W-1:0];
        CFG_OFFSET:     offset     = v[PHASE_W-1:0];
        CFG_TIME_STEP:  time_step  = v[PHASE_W-1:0];
        CFG_COLOR_HIGH: color_high = v[COLOR_W-1:0];
        CFG_COLOR_LOW:  color_low  = v[COLOR_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [LEVEL_W-1:0] sine_level(logic [PHASE_W-1:0] ph);
      int         idx;
      logic [7:0] mag;
      idx = (int'(ph[13:0]) * SINE_N) >> 14;
      // odd quadrants run the table backwards, upper half goes below mid
      mag = ph[14] ? sine_lut[SINE_N - idx] : sine_lut[idx];
      return ph[15] ? LEVEL_MID - mag : LEVEL_MID + mag;
    endfunction

    function logic [CH_W-1:0] mix_channel(logic [LEVEL_W-1:0] v, logic [7:0] hi,
                                          logic [7:0] lo);
      int unsigned acc;
      acc = v * hi + (256 - v) * lo;
      return CH_W'(acc >> 8);
    endfunction

    // pixel_index is 10 bits wide, so it never reaches MAX_LEDS and needs no clamp
    function void note_pixel(logic [PIX_W-1:0] idx, logic last);
      logic [47:0]        prod;
      logic [PHASE_W-1:0] ph;
      logic [LEVEL_W-1:0] v;
      pixels_seen++;
      if (!enable) begin
        frame_time = '0;
        expected_colors.insert(expected_colors.size(), OUT_TDATA_W'(0));
        return;
      end
      prod = 48'(speed) * 48'(frame_time);
      ph   = phase_step * idx - prod[31:16] + offset;
      v    = sine_level(ph);
      expected_colors.insert(expected_colors.size(),
                             {mix_channel(v, color_high[7:0],   color_low[7:0]),
                              mix_channel(v, color_high[15:8],  color_low[15:8]),
                              mix_channel(v, color_high[23:16], color_low[23:16])});
      if (last) begin
        frame_time = frame_time + time_step;
        frames_seen++;
      end
    endfunction

    function void check_color(logic [OUT_TDATA_W-1:0] got);
      logic [OUT_TDATA_W-1:0] want;
      if (expected_colors.size() == 0) begin
        errors++;
        $display("%0t: color %06h arrived with nothing expected", $time, got);
        return;
      end
      want = expected_colors.pop_front();
      for (int c = 0; c < 3; c++) begin
        if (want[c*CH_W +: CH_W] !== got[c*CH_W +: CH_W]) begin
          errors++;
          $display("%0t: %s expected %0d actual %0d", $time,
                   (c == 0) ? "red" : (c == 1) ? "green" : "blue",
                   want[c*CH_W +: CH_W], got[c*CH_W +: CH_W]);
        end
      end
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [9:0] pixel_index
  logic                   in_tlast   = 1'b0; // frame_end
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [7:0] red, [15:8] green, [23:16] blue
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  int send_idle       = 31;
  int recv_idle       = 77;
  int stall_cycles    = 0;
  int settings_loaded = 0;

  color_scoreboard sb;

  sine_wave_led_color_blend u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_pixel(in_tdata[PIX_W-1:0], in_tlast);
      end
      if (out_tvalid && out_tready) begin
        sb.check_color(out_tdata);
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic wave_cfg_t make_wave(logic en, logic [PHASE_W-1:0] step,
                                          logic [PHASE_W-1:0] spd,
                                          logic [PHASE_W-1:0] ofs,
                                          logic [PHASE_W-1:0] tstep,
                                          logic [COLOR_W-1:0] hi,
                                          logic [COLOR_W-1:0] lo);
    wave_cfg_t c;
    c.en         = en;
    c.phase_step = step;
    c.speed      = spd;
    c.offset     = ofs;
    c.tstep      = tstep;
    c.color_high = hi;
    c.color_low  = lo;
    return c;
  endfunction

  // narrow registers get junk above their width, which must be dropped
  function automatic logic [CFG_DATA_W-1:0] reg_word(wave_cfg_t c, cfg_reg_t r);
    case (r)
      CFG_ENABLE:     return {23'($urandom), c.en};
      CFG_PHASE_STEP: return {8'($urandom), c.phase_step};
      CFG_SPEED:      return {8'($urandom), c.speed};
      CFG_OFFSET:     return {8'($urandom), c.offset};
      CFG_TIME_STEP:  return {8'($urandom), c.tstep};
      CFG_COLOR_HIGH: return c.color_high;
      CFG_COLOR_LOW:  return c.color_low;
      default:        return '0;
    endcase
  endfunction

  function automatic logic [PHASE_W-1:0] pick_angle();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return PHASE_W'($urandom);
    endcase
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] idx, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(idx);
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_colors.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic load_wave(input wave_cfg_t c);
    cfg_reg_t              r;
    logic [CFG_DATA_W-1:0] word;
    wait_idle();
    r = r.first();
    do begin
      word = reg_word(c, r);
      cfg_wr_en <= 1'b1;
      cfg_index <= r;
      cfg_wdata <= word;
      sb.set_reg(r, word);
      @(posedge clk);
      r = r.next();
    end while (r != r.first());
    // a write to the unused index must leave every register alone
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_loaded++;
  endtask

  initial begin
    wave_cfg_t        c;
    int               sent;
    int               len;
    logic [PIX_W-1:0] start;

    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // out of reset the block is disabled: black pixels
    send_pixel(10'd0, 1'b1);
    send_pixel(10'd1023, 1'b0);

    // quarter turn per LED walks the four quadrant boundaries
    load_wave(make_wave(1'b1, 16'h4000, '0, '0, '0, 24'hFFFFFF, 24'h000000));
    send_pixel(10'd0, 1'b0);
    send_pixel(10'd1, 1'b0);
    send_pixel(10'd2, 1'b0);
    send_pixel(10'd3, 1'b0);
    send_pixel(10'd1023, 1'b1);

    // everything at full scale, trough color brighter than peak color
    load_wave(make_wave(1'b1, '1, '1, '1, '1, 24'h00FF80, 24'hFFFFFF));
    send_pixel(10'd1023, 1'b1);
    send_pixel(10'd0, 1'b1);
    send_pixel(10'd512, 1'b1);
    send_pixel(10'd1, 1'b0);

    // disabled with frame ends: black, and time drops back to zero
    load_wave(make_wave(1'b0, 16'h0123, 16'h8000, 16'h2000, 16'h8000,
                        24'h123456, 24'hFEDCBA));
    send_pixel(10'd5, 1'b1);
    send_pixel(10'd7, 1'b0);

    load_wave(make_wave(1'b1, 16'h0123, 16'h8000, 16'h2000, 16'h8000,
                        24'h123456, 24'hFEDCBA));
    send_pixel(10'd0, 1'b0);
    send_pixel(10'd1, 1'b0);
    send_pixel(10'd2, 1'b0);
    send_pixel(10'd3, 1'b1);
    send_pixel(10'd1023, 1'b1);

    for (int s = 0; s < RANDOM_PHASES; s++) begin
      send_idle = (s < 3) ? 31 : (s < 6) ? 77 : 0;
      recv_idle = (s < 3) ? 77 : (s < 6) ? 31 : 0;
      c = make_wave(s != 4, pick_angle(), pick_angle(), pick_angle(), pick_angle(),
                    pick_color(), pick_color());
      if (s == 2) begin
        c = '1;
      end else if (s == 5) begin
        c = '0;
        c.en = 1'b1;
        c.color_high = pick_color();
      end
      load_wave(c);

      // mostly whole frames of consecutive LEDs, some stray pixels
      sent = 0;
      while (sent < PHASE_PIXELS) begin
        if ($urandom_range(99) < 80) begin
          len   = $urandom_range(1, 40);
          start = PIX_W'($urandom);
          for (int i = 0; i < len; i++) begin
            send_pixel(start + PIX_W'(i), i == len - 1);
          end
          sent += len;
        end else begin
          send_pixel(PIX_W'($urandom), 1'($urandom));
          sent++;
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d pixels, %0d frame ends, %0d register settings",
             sb.pixels_seen, sb.frames_seen, settings_loaded);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
